### design/pi_pkg.sv
// types, codes and arithmetic helpers shared by the particle integrator
// no dependencies; compiled first
package pi_pkg;

   localparam int DT_BITS = 16;

   typedef logic signed [31:0] fix_type;

   typedef enum logic [2:0] {
      OP_INIT      = 3'd0,
      OP_ADD_FORCE = 3'd1,
      OP_ADD_ACCEL = 3'd2,
      OP_INTEGRATE = 3'd3,
      OP_SET_PIN   = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      STS_OK         = 2'd0,
      STS_ZERO_MASS  = 2'd1,
      STS_SATURATED  = 2'd2
   } status_type;

   localparam logic [1:0] METHOD_EULER = 2'd0;
   localparam logic       REG_METHOD   = 1'b0;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_READ,
      SEQ_EXEC,
      SEQ_MAC_MUL,
      SEQ_MAC_ADD,
      SEQ_DIV_START,
      SEQ_DIV_WAIT,
      SEQ_MUL_A,
      SEQ_STEP_V,
      SEQ_MUL_V,
      SEQ_STEP_P,
      SEQ_WRITE,
      SEQ_DONE
   } seq_state_type;

   typedef struct packed {
      fix_type [2:0] pos;
      fix_type [2:0] vel;
      fix_type [2:0] frc;
      logic [30:0]   mass;
      logic          pinned;
   } entry_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [5:0]  particle_index;
      fix_type     vec_x;
      fix_type     vec_y;
      fix_type     vec_z;
      logic [30:0] mass_value;
      logic [15:0] time_step;
      logic        pin_flag;
   } req_payload_type;

   typedef struct packed {
      logic [5:0] out_index;
      fix_type    pos_x;
      fix_type    pos_y;
      fix_type    pos_z;
      fix_type    vel_x;
      fix_type    vel_y;
      fix_type    vel_z;
      logic [1:0] status;
   } rsp_payload_type;

   typedef struct packed {
      logic        start;
      fix_type     dividend;
      logic [30:0] divisor;
   } div_ctrl_type;

   typedef struct packed {
      logic    busy;
      logic    done;
      logic    sat;
      fix_type quot;
   } div_stat_type;

   typedef struct packed {
      logic    flag;
      fix_type value;
   } sat_type;

   // shift right with rounding to nearest, ties toward plus infinity
   function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] x,
                                                  input int unsigned s);
      logic signed [63:0] bias;
      bias = 64'sd1 <<< (s - 1);
      return (x + bias) >>> s;
   endfunction

   // clamp to signed 32 bits
   function automatic sat_type sat32(input logic signed [63:0] x);
      sat_type r;
      if (x > 64'sd2147483647) begin
         r.flag  = 1'b1;
         r.value = 32'sh7fffffff;
      end else if (x < -64'sd2147483648) begin
         r.flag  = 1'b1;
         r.value = 32'sh80000000;
      end else begin
         r.flag  = 1'b0;
         r.value = x[31:0];
      end
      return r;
   endfunction

endpackage

### design/pi_chan_if.sv
// valid/ready channel carrying one payload per transaction
// no package dependency; the payload type is a parameter
interface pi_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### design/particle_integrator_unit.sv
// particle integrator top level: particle table memory, op sequencer, csr port
// depends on pi_pkg, pi_chan_if and pi_divider
//
// Usage
//   req_chan carries one operation per transaction (init, add force, add
//   acceleration, integrate, set pin) for one particle entry; rsp_chan returns
//   exactly one result per request with the entry's position, velocity and a
//   status code. The csr port (psel/penable/pwrite, pready always high) holds
//   the integration method at byte address 0; write it only while idle.
// Sequencing
//   One request is in flight at a time. Each takes a memory read, the work,
//   a write back when the entry changes and a hand-off to the output
//   register. Add acceleration runs one multiply and add per axis, and
//   integrate runs the bit-serial divider that forms force / mass on each
//   axis in turn.
// Reset
//   Clears the sequencer, the output valid and the method register (Euler).
//   The particle table holds nothing defined until an entry is initialised.
// Stall
//   A finished result sits in the output register until rsp_chan.ready; the
//   next request is taken meanwhile and only waits if its result is ready first.
module particle_integrator_unit import pi_pkg::*; #(
   parameter int NUM_PARTICLES = 64,
   parameter int FRAC_BITS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   pi_chan_if.sink     req_chan,
   pi_chan_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int AW = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;

   entry_type       mem [NUM_PARTICLES];
   entry_type       rd_data_ff;
   seq_state_type   state_ff, state_in;
   req_payload_type req_ff;
   entry_type       entry_ff, entry_in;
   logic [1:0]      axis_ff, axis_in;
   logic            sat_ff, sat_in;
   logic            zmass_ff, zmass_in;
   logic            zero_rep_ff, zero_rep_in;
   logic [1:0]      method_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;
   logic signed [63:0] mac_ff;
   logic signed [47:0] p1_ff;
   logic signed [63:0] p2_ff;
   logic signed [48:0] pv_ff;
   fix_type         a_ff, vn_ff;
   logic            mem_we, load_out, accept;
   logic [AW-1:0]   rd_addr, wr_addr;
   fix_type [2:0]   vec;
   fix_type         cur_vec, cur_pos, cur_vel, cur_frc;
   logic signed [16:0] dt_s;
   logic            in_range, euler;
   div_ctrl_type    div_ctrl;
   div_stat_type    div_stat;
   sat_type         s0, s1, s2;
   logic signed [63:0] adt, vdt, half;

   // handshake
   assign req_chan.ready = (state_ff == SEQ_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // csr register
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff <= METHOD_EULER;
      end else if (psel && penable && pwrite && paddr[2] == REG_METHOD) begin
         method_ff <= pwdata[1:0];
      end
   end
   assign prdata = (paddr[2] == REG_METHOD) ? {30'd0, method_ff} : 32'd0;

   // particle table
   assign rd_addr = AW'(req_chan.payload.particle_index);
   assign wr_addr = AW'(req_ff.particle_index);
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= entry_ff;
      end
      if (accept) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // per-axis selection
   assign vec      = {req_ff.vec_z, req_ff.vec_y, req_ff.vec_x};
   assign cur_vec  = vec[axis_ff];
   assign cur_pos  = entry_ff.pos[axis_ff];
   assign cur_vel  = entry_ff.vel[axis_ff];
   assign cur_frc  = entry_ff.frc[axis_ff];
   assign dt_s     = $signed({1'b0, req_ff.time_step});
   assign in_range = int'(req_ff.particle_index) < NUM_PARTICLES;
   assign euler    = (method_ff == METHOD_EULER);

   // divider for force / mass
   assign div_ctrl.start    = (state_ff == SEQ_DIV_START);
   assign div_ctrl.dividend = cur_frc;
   assign div_ctrl.divisor  = entry_ff.mass;

   pi_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

   // rounded products
   assign adt  = rnd_shr(64'(p1_ff), DT_BITS);
   assign vdt  = rnd_shr(64'(pv_ff), DT_BITS);
   assign half = euler ? 64'sd0 : rnd_shr(p2_ff, 2 * DT_BITS + 1);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      entry_in    = entry_ff;
      axis_in     = axis_ff;
      sat_in      = sat_ff;
      zmass_in    = zmass_ff;
      zero_rep_in = zero_rep_ff;
      mem_we      = 1'b0;
      load_out    = 1'b0;
      s0 = sat32(64'(entry_ff.frc[0]) + 64'(req_ff.vec_x));
      s1 = sat32(64'(entry_ff.frc[1]) + 64'(req_ff.vec_y));
      s2 = sat32(64'(entry_ff.frc[2]) + 64'(req_ff.vec_z));
      case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               state_in    = SEQ_READ;
               sat_in      = 1'b0;
               zmass_in    = 1'b0;
               zero_rep_in = 1'b0;
               axis_in     = 2'd0;
            end
         end
         SEQ_READ: begin
            entry_in = rd_data_ff;
            state_in = SEQ_EXEC;
         end
         SEQ_EXEC: begin
            state_in = SEQ_DONE;
            if (!in_range) begin
               zero_rep_in = 1'b1;
            end else begin
               case (req_ff.opcode)
                  OP_INIT: begin
                     if (req_ff.mass_value == '0) begin
                        zero_rep_in = 1'b1;
                        zmass_in    = 1'b1;
                     end else begin
                        entry_in.pos    = vec;
                        entry_in.vel    = '0;
                        entry_in.frc    = '0;
                        entry_in.mass   = req_ff.mass_value;
                        entry_in.pinned = 1'b0;
                        state_in        = SEQ_WRITE;
                     end
                  end
                  OP_ADD_FORCE: begin
                     entry_in.frc[0] = s0.value;
                     entry_in.frc[1] = s1.value;
                     entry_in.frc[2] = s2.value;
                     sat_in   = s0.flag || s1.flag || s2.flag;
                     state_in = SEQ_WRITE;
                  end
                  OP_ADD_ACCEL: begin
                     state_in = SEQ_MAC_MUL;
                  end
                  OP_INTEGRATE: begin
                     if (entry_ff.pinned) begin
                        state_in = SEQ_DONE;
                     end else if (entry_ff.mass == '0) begin
                        zmass_in = 1'b1;
                     end else begin
                        state_in = SEQ_DIV_START;
                     end
                  end
                  OP_SET_PIN: begin
                     entry_in.pinned = req_ff.pin_flag;
                     state_in        = SEQ_WRITE;
                  end
                  default: begin
                     state_in = SEQ_DONE;
                  end
               endcase
            end
         end
         SEQ_MAC_MUL: begin
            state_in = SEQ_MAC_ADD;
         end
         SEQ_MAC_ADD: begin
            s0 = sat32(64'(cur_frc) + rnd_shr(mac_ff, FRAC_BITS));
            entry_in.frc[axis_ff] = s0.value;
            sat_in  = sat_ff || s0.flag;
            axis_in = axis_ff + 2'd1;
            state_in = (axis_ff == 2'd2) ? SEQ_WRITE : SEQ_MAC_MUL;
         end
         SEQ_DIV_START: begin
            state_in = SEQ_DIV_WAIT;
         end
         SEQ_DIV_WAIT: begin
            if (div_stat.done) begin
               sat_in   = sat_ff || div_stat.sat;
               state_in = SEQ_MUL_A;
            end
         end
         SEQ_MUL_A: begin
            state_in = SEQ_STEP_V;
         end
         SEQ_STEP_V: begin
            s0 = sat32(64'(cur_vel) + adt);
            sat_in   = sat_ff || s0.flag;
            state_in = SEQ_MUL_V;
         end
         SEQ_MUL_V: begin
            state_in = SEQ_STEP_P;
         end
         SEQ_STEP_P: begin
            s0 = sat32(64'(cur_pos) + vdt + half);
            entry_in.pos[axis_ff] = s0.value;
            entry_in.vel[axis_ff] = vn_ff;
            entry_in.frc[axis_ff] = '0;
            sat_in   = sat_ff || s0.flag;
            axis_in  = axis_ff + 2'd1;
            state_in = (axis_ff == 2'd2) ? SEQ_WRITE : SEQ_DIV_START;
         end
         SEQ_WRITE: begin
            mem_we   = 1'b1;
            state_in = SEQ_DONE;
         end
         SEQ_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_out = 1'b1;
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working registers and multiplier stages
   always_ff @(posedge clock) begin
      entry_ff    <= entry_in;
      axis_ff     <= axis_in;
      sat_ff      <= sat_in;
      zmass_ff    <= zmass_in;
      zero_rep_ff <= zero_rep_in;
      if (accept) begin
         req_ff <= req_chan.payload;
      end
      if (state_ff == SEQ_MAC_MUL) begin
         mac_ff <= $signed({1'b0, entry_ff.mass}) * cur_vec;
      end
      if (state_ff == SEQ_DIV_WAIT && div_stat.done) begin
         a_ff <= div_stat.quot;
      end
      if (state_ff == SEQ_MUL_A) begin
         p1_ff <= 48'(a_ff * dt_s);
      end
      if (state_ff == SEQ_STEP_V) begin
         vn_ff <= s0.value;
         p2_ff <= 64'(p1_ff * dt_s);
      end
      if (state_ff == SEQ_MUL_V) begin
         pv_ff <= 49'((euler ? vn_ff : cur_vel) * dt_s);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff.out_index <= req_ff.particle_index;
         rsp_data_ff.pos_x <= zero_rep_ff ? '0 : entry_ff.pos[0];
         rsp_data_ff.pos_y <= zero_rep_ff ? '0 : entry_ff.pos[1];
         rsp_data_ff.pos_z <= zero_rep_ff ? '0 : entry_ff.pos[2];
         rsp_data_ff.vel_x <= zero_rep_ff ? '0 : entry_ff.vel[0];
         rsp_data_ff.vel_y <= zero_rep_ff ? '0 : entry_ff.vel[1];
         rsp_data_ff.vel_z <= zero_rep_ff ? '0 : entry_ff.vel[2];
         rsp_data_ff.status <= zmass_ff ? STS_ZERO_MASS :
                               (sat_ff ? STS_SATURATED : STS_OK);
      end
   end

   a_read_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == SEQ_READ) else $error("read not issued");
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> in_range) else $error("write to entry out of range");
   a_zero_mass_no_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !zmass_ff) else $error("rejected transaction written back");
   a_div_only_integrate: assert property (@(posedge clock) disable iff (reset)
      div_ctrl.start |-> req_ff.opcode == OP_INTEGRATE)
      else $error("divider started outside integrate");

endmodule

### design/pi_divider.sv
// restoring divider for acceleration = force * 2^frac / mass, one bit per cycle
// depends on pi_pkg
module pi_divider import pi_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  div_ctrl_type ctrl,
   output div_stat_type stat
);
   localparam int NW = 32 + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);

   logic          busy_ff, done_ff, neg_ff;
   logic [CW-1:0] cnt_ff;
   logic [31:0]   rem_ff;
   logic [NW-1:0] num_ff;
   logic [30:0]   den_ff;
   logic [31:0]   trial;
   logic          qbit;
   logic [31:0]   mag;
   logic          sat_pos, sat_neg;

   // magnitude of the dividend
   assign mag = ctrl.dividend[31] ? 32'(-ctrl.dividend) : 32'(ctrl.dividend);

   // one restoring step
   assign trial = {rem_ff[30:0], num_ff[NW-1]};
   assign qbit  = (trial >= {1'b0, den_ff});

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (cnt_ff == CW'(NW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // datapath, quotient bits shift in as dividend bits shift out
   always_ff @(posedge clock) begin
      if (ctrl.start && !busy_ff) begin
         rem_ff <= '0;
         num_ff <= {mag, FRAC_BITS'(0)};
         den_ff <= ctrl.divisor;
         neg_ff <= ctrl.dividend[31];
      end else if (busy_ff) begin
         rem_ff <= qbit ? (trial - {1'b0, den_ff}) : trial;
         num_ff <= {num_ff[NW-2:0], qbit};
      end
   end

   // saturate the signed quotient to 32 bits
   assign sat_pos = |num_ff[NW-1:31];
   assign sat_neg = (|num_ff[NW-1:32]) || (num_ff[31] && (|num_ff[30:0]));

   always_comb begin
      stat.busy = busy_ff;
      stat.done = done_ff;
      if (neg_ff) begin
         stat.sat  = sat_neg;
         stat.quot = sat_neg ? 32'sh80000000 : fix_type'(-num_ff[31:0]);
      end else begin
         stat.sat  = sat_pos;
         stat.quot = sat_pos ? 32'sh7fffffff : fix_type'(num_ff[31:0]);
      end
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> !busy_ff) else $error("divider started while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divider done held");

endmodule
